### sv/priority_interrupt_controller_core_assert.svh
// Assertion macros shared by the checker of the interrupt controller.
`ifndef PRIORITY_INTERRUPT_CONTROLLER_CORE_ASSERT_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define PIC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interrupt controller check failed");

// Next-cycle implication, off while reset is high.
`define PIC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interrupt controller check failed");

// Same-cycle implication that is checked through reset as well.
`define PIC_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("interrupt controller check failed");

`endif

### sv/pic_pkg.sv
`default_nettype none

package pic_pkg;

   // Item modes.
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_RAISE = 2'd2;

   // Command byte bit positions.
   localparam int CMD_POLL_BIT     = 2;
   localparam int CMD_OCW3_BIT     = 3;
   localparam int CMD_ICW1_BIT     = 4;
   localparam int CMD_EOI_BIT      = 5;
   localparam int CMD_SPECIFIC_BIT = 6;
   localparam int ICW1_ICW4_BIT    = 0;
   localparam int ICW1_SINGLE_BIT  = 1;

   localparam logic [1:0] OCW3_READ_RAISED = 2'b11;
   localparam logic [7:0] BASE_MASK        = 8'hF8;
   localparam logic [7:0] POLL_NONE        = 8'hFF;

   // Initialization sequence steps.
   localparam logic [2:0] INIT_ICW1     = 3'd0;
   localparam logic [2:0] INIT_ICW2     = 3'd1;
   localparam logic [2:0] INIT_ICW3     = 3'd2;
   localparam logic [2:0] INIT_ICW4     = 3'd3;
   localparam logic [2:0] INIT_COMPLETE = 3'd4;

   typedef struct packed {
      logic [1:0] mode;
      logic       port_select;
      logic [7:0] write_data;
      logic [2:0] irq_line;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       intr_fire;
      logic [7:0] intr_vector;
      logic       raise_rejected;
   } result_type;

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [2:0] lowest_set(input logic [7:0] bits);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (bits[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

### sv/pic_if.sv
`default_nettype none

// Request channel: one bus read, bus write or line raise per item.
interface pic_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       port_select;
   logic [7:0] write_data;
   logic [2:0] irq_line;

   modport source (output valid, mode, port_select, write_data, irq_line, input ready);
   modport sink   (input valid, mode, port_select, write_data, irq_line, output ready);
endinterface

// Response channel: one result item per request item.
interface pic_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       intr_fire;
   logic [7:0] intr_vector;
   logic       raise_rejected;

   modport source (output valid, read_data, intr_fire, intr_vector, raise_rejected,
                   input ready);
   modport sink   (input valid, read_data, intr_fire, intr_vector, raise_rejected,
                   output ready);
endinterface

`default_nettype wire

### sv/pic_engine.sv
`default_nettype none

// Controller state and the update that one item applies to it.
module pic_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 go,
   input  wire pic_pkg::item_type    item,
   output pic_pkg::result_type       result
);

   logic [7:0] raised_ff, raised_in;
   logic [7:0] mask_ff, mask_in;
   logic       act_valid_ff, act_valid_in;
   logic [2:0] act_line_ff, act_line_in;
   logic [7:0] base_ff, base_in;
   logic [2:0] init_step_ff, init_step_in;
   logic       need_icw4_ff, need_icw4_in;
   logic       cascade_ff, cascade_in;
   logic       poll_ff, poll_in;
   logic       read_raised_ff, read_raised_in;

   logic       do_eoi;
   logic       eoi_specific;
   logic       eoi_clears;
   logic [2:0] eoi_line;
   logic [7:0] eoi_result;
   logic       do_update;
   logic [7:0] raised_a;
   logic       act_valid_a;
   logic [2:0] act_line_a;
   logic [7:0] below;
   logic [7:0] candidates;
   logic [2:0] winner;
   logic [2:0] step_a;
   logic [7:0] data;
   pic_pkg::result_type res_a;

   assign data = item.write_data;

   // First phase: decode the item and apply reads, writes, raises and end of interrupt.
   always_comb begin
      mask_in        = mask_ff;
      base_in        = base_ff;
      init_step_in   = init_step_ff;
      need_icw4_in   = need_icw4_ff;
      cascade_in     = cascade_ff;
      poll_in        = poll_ff;
      read_raised_in = read_raised_ff;
      raised_a       = raised_ff;
      act_valid_a    = act_valid_ff;
      act_line_a     = act_line_ff;
      res_a          = '0;
      do_eoi         = 1'b0;
      eoi_specific   = 1'b0;
      do_update      = 1'b0;
      step_a         = init_step_ff;

      case (item.mode)
         pic_pkg::MODE_READ: begin
            if (item.port_select) begin
               res_a.read_data = mask_ff;
            end else if (poll_ff) begin
               do_eoi = 1'b1;
            end else if (read_raised_ff) begin
               res_a.read_data = raised_ff;
            end else if (act_valid_ff) begin
               res_a.read_data = 8'd1 << act_line_ff;
            end
         end
         pic_pkg::MODE_WRITE: begin
            if (item.port_select) begin
               if (init_step_ff >= pic_pkg::INIT_COMPLETE) begin
                  mask_in = data;
               end else begin
                  // Walk the init sequence, skipping steps the ICW1 bits leave out.
                  case (init_step_ff)
                     pic_pkg::INIT_ICW1: begin
                        need_icw4_in = data[pic_pkg::ICW1_ICW4_BIT];
                        cascade_in   = ~data[pic_pkg::ICW1_SINGLE_BIT];
                        step_a       = pic_pkg::INIT_ICW2;
                     end
                     pic_pkg::INIT_ICW2: begin
                        base_in = data & pic_pkg::BASE_MASK;
                        step_a  = pic_pkg::INIT_ICW3;
                     end
                     pic_pkg::INIT_ICW3: step_a = pic_pkg::INIT_ICW4;
                     default:            step_a = pic_pkg::INIT_COMPLETE;
                  endcase
                  if (step_a == pic_pkg::INIT_ICW3 && !cascade_in) begin
                     step_a = pic_pkg::INIT_ICW4;
                  end
                  if (step_a == pic_pkg::INIT_ICW4 && !need_icw4_in) begin
                     step_a = pic_pkg::INIT_COMPLETE;
                  end
                  init_step_in = step_a;
               end
            end else if (data[pic_pkg::CMD_ICW1_BIT]) begin
               // ICW1 clears everything and starts the init sequence.
               raised_a       = '0;
               mask_in        = '0;
               act_valid_a    = 1'b0;
               act_line_a     = '0;
               base_in        = '0;
               poll_in        = 1'b0;
               read_raised_in = 1'b0;
               need_icw4_in   = data[pic_pkg::ICW1_ICW4_BIT];
               cascade_in     = ~data[pic_pkg::ICW1_SINGLE_BIT];
               init_step_in   = pic_pkg::INIT_ICW2;
            end else if (!data[pic_pkg::CMD_OCW3_BIT]) begin
               do_eoi       = data[pic_pkg::CMD_EOI_BIT];
               eoi_specific = data[pic_pkg::CMD_SPECIFIC_BIT];
            end else begin
               poll_in        = data[pic_pkg::CMD_POLL_BIT];
               read_raised_in = (data[1:0] == pic_pkg::OCW3_READ_RAISED);
            end
         end
         pic_pkg::MODE_RAISE: begin
            if (mask_ff[item.irq_line]) begin
               res_a.raise_rejected = 1'b1;
            end else begin
               raised_a  = raised_ff | (8'd1 << item.irq_line);
               do_update = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // End of interrupt: specific line, else the active one if any.
      eoi_clears = eoi_specific || act_valid_ff;
      eoi_line   = eoi_specific ? data[2:0] : act_line_ff;
      eoi_result = pic_pkg::POLL_NONE;
      if (do_eoi) begin
         do_update = 1'b1;
         if (eoi_clears) begin
            raised_a    = raised_ff & ~(8'd1 << eoi_line);
            act_valid_a = 1'b0;
            act_line_a  = '0;
            eoi_result  = {5'd0, eoi_line};
         end
         if (item.mode == pic_pkg::MODE_READ) begin
            res_a.read_data = eoi_result;
         end
      end
   end

   // Second phase: the lowest-numbered raised line below the active one preempts it.
   always_comb begin
      below      = act_valid_a ? ((8'd1 << act_line_a) - 8'd1) : 8'hFF;
      candidates = raised_a & below;
      winner     = pic_pkg::lowest_set(candidates);
      raised_in    = raised_a;
      act_valid_in = act_valid_a;
      act_line_in  = act_line_a;
      result       = res_a;
      if (do_update && (candidates != '0)) begin
         act_valid_in       = 1'b1;
         act_line_in        = winner;
         result.intr_fire   = 1'b1;
         result.intr_vector = base_ff + {5'd0, winner};
      end
   end

   // State registers advance only when an item is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         raised_ff      <= '0;
         mask_ff        <= '0;
         act_valid_ff   <= 1'b0;
         act_line_ff    <= '0;
         base_ff        <= '0;
         init_step_ff   <= pic_pkg::INIT_COMPLETE;
         need_icw4_ff   <= 1'b0;
         cascade_ff     <= 1'b0;
         poll_ff        <= 1'b0;
         read_raised_ff <= 1'b0;
      end else if (go) begin
         raised_ff      <= raised_in;
         mask_ff        <= mask_in;
         act_valid_ff   <= act_valid_in;
         act_line_ff    <= act_line_in;
         base_ff        <= base_in;
         init_step_ff   <= init_step_in;
         need_icw4_ff   <= need_icw4_in;
         cascade_ff     <= cascade_in;
         poll_ff        <= poll_in;
         read_raised_ff <= read_raised_in;
      end
   end

endmodule

`default_nettype wire

### sv/priority_interrupt_controller_core.sv
// Eight-line interrupt controller in the style of the 8259. Each request item
// is one bus read, one bus write or one line raise, and each gives exactly one
// response item. The block takes one item per clock cycle while the response
// channel does not stall it: an item is held in an input register, the
// controller state and the result are computed from it, and the result is held
// in an output register, from which the item's response is offered. The input
// register keeps taking items while a response waits to be taken, until both
// registers hold an item. The state update (priority encode of the raised
// lines and the vector add) sets the rate.
`default_nettype none

module priority_interrupt_controller_core (
   input  wire logic  clock,
   input  wire logic  reset,
   pic_req_if.sink    req_ch,
   pic_rsp_if.source  rsp_ch
);

   logic                 in_valid_ff, in_valid_in;
   pic_pkg::item_type    in_item_ff, in_item_in;
   logic                 out_valid_ff, out_valid_in;
   pic_pkg::result_type  out_res_ff, out_res_in;
   pic_pkg::result_type  engine_res;
   logic                 advance;

   // The held item moves on when the output register is free or being emptied.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   pic_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .item   (in_item_ff),
      .result (engine_res)
   );

   // Input and output register next values.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
         in_item_in  = '{mode:        req_ch.mode,
                         port_select: req_ch.port_select,
                         write_data:  req_ch.write_data,
                         irq_line:    req_ch.irq_line};
      end
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_res_in   = engine_res;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   // Response channel.
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.read_data      = out_res_ff.read_data;
   assign rsp_ch.intr_fire      = out_res_ff.intr_fire;
   assign rsp_ch.intr_vector    = out_res_ff.intr_vector;
   assign rsp_ch.raise_rejected = out_res_ff.raise_rejected;

endmodule

`default_nettype wire

### sv/pic_checker.sv
`default_nettype none

`include "priority_interrupt_controller_core_assert.svh"

// Port-level checks for the interrupt controller.
module pic_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_intr_fire,
   input wire logic [7:0] rsp_intr_vector,
   input wire logic       rsp_raise_rejected
);

   // A stalled response item holds its value.
   `PIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_intr_vector) && $stable(rsp_intr_fire))

   // The vector is only shown with a fire.
   `PIC_ASSERT_IMPLY(a_vector_needs_fire, clock, reset, rsp_valid && !rsp_intr_fire, rsp_intr_vector == 8'd0)

   // A dropped raise changes nothing, so it neither fires nor reads.
   `PIC_ASSERT_IMPLY(a_reject_alone, clock, reset, rsp_valid && rsp_raise_rejected, !rsp_intr_fire && rsp_read_data == 8'd0)

   // Right after reset both registers are empty.
   `PIC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), req_ready && !rsp_valid)

endmodule

bind priority_interrupt_controller_core pic_checker u_pic_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_read_data      (rsp_ch.read_data),
   .rsp_intr_fire      (rsp_ch.intr_fire),
   .rsp_intr_vector    (rsp_ch.intr_vector),
   .rsp_raise_rejected (rsp_ch.raise_rejected)
);

`default_nettype wire
